### sv/strip_gain_pan_ramp_top_macros.svh
`ifndef STRIP_GAIN_PAN_RAMP_TOP_MACROS_SVH
`define STRIP_GAIN_PAN_RAMP_TOP_MACROS_SVH

// Check cons in the cycle after ante; skipped while reset is high.
`define SGPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Same check, but also evaluated across reset.
`define SGPR_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### sv/sgpr_pkg.sv
`default_nettype none

package sgpr_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int RAMP_BITS   = 16;
  localparam int LEVEL_BITS  = 16;

  // Item kinds
  localparam logic ACT_SET_LEVEL = 1'b0;
  localparam logic ACT_FRAME     = 1'b1;

  // Gain Q7.16 unsigned
  localparam int GAIN_BITS = 23;
  localparam logic [GAIN_BITS-1:0] GAIN_MAX   = '1;
  localparam logic [GAIN_BITS-1:0] UNITY_GAIN = GAIN_BITS'(65536);

  // Pan Q2.14 signed, pan law factor 0..1.0 unsigned
  localparam int PAN_BITS  = 16;
  localparam int PANF_BITS = 15;
  localparam logic signed [PAN_BITS-1:0] PAN_ONE     = 16'sd16384;
  localparam logic signed [PAN_BITS-1:0] PAN_NEG_ONE = -16'sd16384;

  // Level limits, Q8.8 dB
  localparam logic signed [LEVEL_BITS-1:0] TRIM_MIN  = -16'sd6144;
  localparam logic signed [LEVEL_BITS-1:0] TRIM_MAX  = 16'sd6144;
  localparam logic signed [LEVEL_BITS-1:0] FADER_MIN = -16'sd15360;
  localparam logic signed [LEVEL_BITS-1:0] FADER_MAX = 16'sd2560;
  localparam int DB_BITS = LEVEL_BITS + 1;

  // dB to base-2 exponent: log2(10)/20 in Q16, exponent with 24 fraction bits
  localparam int DB_LOG2_K = 10885;
  localparam int X_FRAC    = 24;
  localparam int J_BITS    = 4;
  localparam int R_BITS    = X_FRAC - J_BITS;
  localparam int E_BITS    = 5;
  localparam int MANT_BITS = 18;
  localparam int SHIFT_W   = MANT_BITS + (1 << (E_BITS - 1));

  // Shared multiplier
  localparam int MUL_W  = ((SAMPLE_BITS > GAIN_BITS + 1) ? SAMPLE_BITS : GAIN_BITS + 1) + 1;
  localparam int PROD_W = 2 * MUL_W;

  // gain * pan factor is split in two halves for the sample multiply
  localparam int GP_W      = GAIN_BITS + PANF_BITS;
  localparam int GP_LO     = (GP_W + 1) / 2;
  localparam int GP_HI     = GP_W - GP_LO;
  localparam int ACC_W     = SAMPLE_BITS + GP_W;
  localparam int RND_SHIFT = 30;

  // Serial divider
  localparam int DIV_W = GAIN_BITS + 1;
  localparam int CNT_W = $clog2(DIV_W);

  typedef logic signed [MUL_W-1:0]  mul_op_t;
  typedef logic signed [PROD_W-1:0] mul_prod_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [RAMP_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // 2^(idx/16) in Q16
  function automatic logic [MANT_BITS-1:0] exp2_tab(input logic [J_BITS:0] idx);
    logic [MANT_BITS-1:0] v;
    case (idx)
      5'd0:    v = 18'd65536;
      5'd1:    v = 18'd68438;
      5'd2:    v = 18'd71468;
      5'd3:    v = 18'd74632;
      5'd4:    v = 18'd77936;
      5'd5:    v = 18'd81386;
      5'd6:    v = 18'd84990;
      5'd7:    v = 18'd88752;
      5'd8:    v = 18'd92682;
      5'd9:    v = 18'd96785;
      5'd10:   v = 18'd101070;
      5'd11:   v = 18'd105545;
      5'd12:   v = 18'd110218;
      5'd13:   v = 18'd115097;
      5'd14:   v = 18'd120193;
      5'd15:   v = 18'd125515;
      default: v = 18'd131072;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### sv/sgpr_mul.sv
`default_nettype none

module sgpr_mul
  import sgpr_pkg::*;
(
  input  logic      clk,
  input  mul_op_t   a,
  input  mul_op_t   b,
  output mul_prod_t prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

### sv/sgpr_div.sv
`default_nettype none

module sgpr_div
  import sgpr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_W-1:0]     dvd;
  logic [RAMP_BITS-1:0] rem;
  logic [RAMP_BITS-1:0] divisor;
  logic [RAMP_BITS:0]   partial;
  logic [RAMP_BITS:0]   trial;
  logic                 fits;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    partial = {rem, dvd[DIV_W-1]};
    trial   = partial - {1'b0, divisor};
    fits    = !trial[RAMP_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift into the dividend register from the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd     <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? trial[RAMP_BITS-1:0] : partial[RAMP_BITS-1:0];
      dvd <= {dvd[DIV_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

`default_nettype wire

### sv/strip_gain_pan_ramp_top.sv
`default_nettype none

// Level stage of one mixer strip. A set-level item (action 0) saturates trim, fader and pan,
// converts trim + fader from dB to a Q7.16 gain and either jumps to it (ramp_frames 0) or
// starts a linear glide of gain and pan over ramp_frames frames; it gives no result. A frame
// item (action 1) scales the stereo sample by the current gain and, when mono_source is set,
// by the pan law min(1, 1 -/+ pan), gives one result and advances the glide by one frame.
// Everything runs on one registered multiplier and one bit-per-cycle divider under a small
// sequencer, so in_ready is low while an item is in progress. An active frame item makes six
// multiplier passes, with round and saturate per channel; an inactive one gives zeros. A
// set-level item with a glide is dominated by the two 24-bit divisions of the gain and pan
// differences by the frame count. A finished result waits in the output register, and the
// next item is accepted meanwhile; a new result is held back until the waiting one is taken.

module strip_gain_pan_ramp_top
  import sgpr_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic signed [LEVEL_BITS-1:0]  trim_db,
  input  logic signed [LEVEL_BITS-1:0]  fader_db,
  input  logic signed [LEVEL_BITS-1:0]  pan_pos,
  input  logic        [LEVEL_BITS-1:0]  ramp_frames,
  input  logic                          active,
  input  logic signed [SAMPLE_BITS-1:0] in_left,
  input  logic signed [SAMPLE_BITS-1:0] in_right,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right,
  output logic                          ramping
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LVL   = 5'd1;
  localparam logic [4:0] S_MULX  = 5'd2;
  localparam logic [4:0] S_EXP   = 5'd3;
  localparam logic [4:0] S_MULF  = 5'd4;
  localparam logic [4:0] S_MANT  = 5'd5;
  localparam logic [4:0] S_SHIFT = 5'd6;
  localparam logic [4:0] S_JUMP  = 5'd7;
  localparam logic [4:0] S_DIVG  = 5'd8;
  localparam logic [4:0] S_DIVP  = 5'd9;
  localparam logic [4:0] S_PANF  = 5'd10;
  localparam logic [4:0] S_GP    = 5'd11;
  localparam logic [4:0] S_LO    = 5'd12;
  localparam logic [4:0] S_HI    = 5'd13;
  localparam logic [4:0] S_ACC   = 5'd14;
  localparam logic [4:0] S_ABS   = 5'd15;
  localparam logic [4:0] S_RND   = 5'd16;
  localparam logic [4:0] S_FIN   = 5'd17;

  localparam logic [31:0] RAMP_MAX = (32'd1 << RAMP_BITS) - 32'd1;
  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (RND_SHIFT - 1);
  localparam logic [ACC_W-1:0] SAT_MAG  = ACC_W'(1) << (SAMPLE_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SHIFT_W-1:0] SHIFT_ONE = SHIFT_W'(1);
  localparam logic [DIV_W-1:0] PAN_STEP_MAX = DIV_W'((1 << (PAN_BITS - 1)) - 1);

  // Control and strip state
  logic [4:0]                  state;
  logic                        mono_source;
  logic [GAIN_BITS-1:0]        current_gain;
  logic [GAIN_BITS-1:0]        target_gain;
  logic signed [DIV_W-1:0]     gain_step;
  logic signed [PAN_BITS-1:0]  current_pan;
  logic signed [PAN_BITS-1:0]  target_pan;
  logic signed [PAN_BITS-1:0]  pan_step;
  logic [RAMP_BITS-1:0]        frames_left;

  // Item and work registers
  logic                        active_r;
  logic signed [LEVEL_BITS-1:0] trim_r;
  logic signed [LEVEL_BITS-1:0] fader_r;
  logic signed [LEVEL_BITS-1:0] pan_r;
  logic [LEVEL_BITS-1:0]       frames_r;
  logic signed [SAMPLE_BITS-1:0] left_r;
  logic signed [SAMPLE_BITS-1:0] right_r;
  logic signed [DB_BITS-1:0]   db;
  logic signed [PAN_BITS-1:0]  pan_c;
  logic [RAMP_BITS-1:0]        n;
  logic signed [E_BITS-1:0]    e_r;
  logic [R_BITS-1:0]           r_r;
  logic [MANT_BITS-1:0]        base_r;
  logic [MANT_BITS-1:0]        slope_r;
  logic [MANT_BITS-1:0]        m_r;
  logic [PANF_BITS-1:0]        lpf;
  logic [PANF_BITS-1:0]        rpf;
  logic                        side;
  logic [GP_W-1:0]             gp;
  logic signed [ACC_W-1:0]     acc;
  logic [ACC_W-1:0]            mag;
  logic                        neg;
  logic                        div_neg;
  logic [SAMPLE_BITS-1:0]      res_l;
  logic [SAMPLE_BITS-1:0]      res_r;

  // Combinational
  logic signed [LEVEL_BITS-1:0] trim_c;
  logic signed [LEVEL_BITS-1:0] fader_c;
  logic signed [LEVEL_BITS-1:0] pan_cl;
  logic [31:0]                 n_wide;
  logic [RAMP_BITS-1:0]        n_clamp;
  logic [J_BITS-1:0]           j;
  logic [MANT_BITS-1:0]        tab_lo;
  logic [MANT_BITS-1:0]        tab_hi;
  logic [SHIFT_W-1:0]          m_ext;
  logic [SHIFT_W-1:0]          gw;
  logic [E_BITS-1:0]           sh;
  logic [GAIN_BITS-1:0]        g_sat;
  logic signed [PAN_BITS+1:0]  cp_x;
  logic signed [PAN_BITS+1:0]  lraw;
  logic signed [PAN_BITS+1:0]  rraw;
  logic [PANF_BITS-1:0]        lpf_v;
  logic [PANF_BITS-1:0]        rpf_v;
  logic [DIV_W-1:0]            gdiff;
  logic [DIV_W-1:0]            gmag;
  logic signed [PAN_BITS:0]    pdiff;
  logic [PAN_BITS:0]           pmag;
  logic signed [ACC_W-1:0]     prod_x;
  logic [ACC_W-1:0]            rnd;
  logic [SAMPLE_BITS-1:0]      res_v;
  logic [DIV_W-1:0]            quo;
  logic [DIV_W-1:0]            gstep_v;
  logic [PAN_BITS-1:0]         pstep_v;
  logic [DIV_W-1:0]            gain_sum;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                        fin_go;

  mul_op_t   mul_a;
  mul_op_t   mul_b;
  mul_prod_t prod;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  sgpr_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  sgpr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ready = (state == S_IDLE) && !rst;
  assign fin_go   = (state == S_FIN) && (!out_valid || out_ready);
  assign sample   = side ? right_r : left_r;
  assign quo      = div_rsp.quotient;

  // Level saturation
  always_comb begin
    trim_c  = trim_r;
    fader_c = fader_r;
    pan_cl  = pan_r;
    if (trim_r < TRIM_MIN) trim_c = TRIM_MIN;
    if (trim_r > TRIM_MAX) trim_c = TRIM_MAX;
    if (fader_r < FADER_MIN) fader_c = FADER_MIN;
    if (fader_r > FADER_MAX) fader_c = FADER_MAX;
    if (pan_r < PAN_NEG_ONE) pan_cl = PAN_NEG_ONE;
    if (pan_r > PAN_ONE) pan_cl = PAN_ONE;
    n_wide  = {{(32-LEVEL_BITS){1'b0}}, frames_r};
    n_clamp = (n_wide > RAMP_MAX) ? RAMP_MAX[RAMP_BITS-1:0] : n_wide[RAMP_BITS-1:0];
  end

  // Table lookup and exponent shift
  always_comb begin
    j      = prod[R_BITS+J_BITS-1:R_BITS];
    tab_lo = exp2_tab({1'b0, j});
    tab_hi = exp2_tab({1'b0, j} + 5'd1);
    m_ext  = {{(SHIFT_W-MANT_BITS){1'b0}}, m_r};
    sh     = E_BITS'(-e_r);
    if (!e_r[E_BITS-1]) begin
      gw = m_ext << e_r[E_BITS-2:0];
    end else begin
      // round half up on the way down
      gw = (m_ext + (SHIFT_ONE << (sh - 1'b1))) >> sh;
    end
    g_sat = (gw > {{(SHIFT_W-GAIN_BITS){1'b0}}, GAIN_MAX}) ? GAIN_MAX : gw[GAIN_BITS-1:0];
  end

  // Pan law factors
  always_comb begin
    cp_x  = {{2{current_pan[PAN_BITS-1]}}, current_pan};
    lraw  = {{2{1'b0}}, PAN_ONE} - cp_x;
    rraw  = {{2{1'b0}}, PAN_ONE} + cp_x;
    lpf_v = PAN_ONE[PANF_BITS-1:0];
    rpf_v = PAN_ONE[PANF_BITS-1:0];
    if (mono_source) begin
      if (lraw[PAN_BITS+1]) lpf_v = '0;
      else if (lraw < {{2{1'b0}}, PAN_ONE}) lpf_v = lraw[PANF_BITS-1:0];
      if (rraw[PAN_BITS+1]) rpf_v = '0;
      else if (rraw < {{2{1'b0}}, PAN_ONE}) rpf_v = rraw[PANF_BITS-1:0];
    end
  end

  // Ramp step operands and results
  always_comb begin
    gdiff = {1'b0, target_gain} - {1'b0, current_gain};
    gmag  = gdiff[DIV_W-1] ? -gdiff : gdiff;
    pdiff = {pan_c[PAN_BITS-1], pan_c} - {current_pan[PAN_BITS-1], current_pan};
    pmag  = pdiff[PAN_BITS] ? -pdiff : pdiff;
    gstep_v = div_neg ? -quo : quo;
    if (div_neg) pstep_v = -quo[PAN_BITS-1:0];
    else if (quo > PAN_STEP_MAX) pstep_v = PAN_STEP_MAX[PAN_BITS-1:0];
    else pstep_v = quo[PAN_BITS-1:0];
    gain_sum = {1'b0, current_gain} + gain_step;
  end

  // Sample scaling: accumulate, round half away from zero, saturate
  always_comb begin
    prod_x = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    rnd    = (mag + RND_HALF) >> RND_SHIFT;
    if (rnd >= SAT_MAG) res_v = neg ? SMIN : SMAX;
    else res_v = neg ? -rnd[SAMPLE_BITS-1:0] : rnd[SAMPLE_BITS-1:0];
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MULX: begin
        mul_a = {{(MUL_W-DB_BITS){db[DB_BITS-1]}}, db};
        mul_b = MUL_W'(DB_LOG2_K);
      end
      S_MULF: begin
        mul_a = {{(MUL_W-MANT_BITS){1'b0}}, slope_r};
        mul_b = {{(MUL_W-R_BITS){1'b0}}, r_r};
      end
      S_GP: begin
        mul_a = {{(MUL_W-GAIN_BITS){1'b0}}, current_gain};
        mul_b = {{(MUL_W-PANF_BITS){1'b0}}, (side ? rpf : lpf)};
      end
      S_LO: begin
        mul_a = {{(MUL_W-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
        mul_b = {{(MUL_W-GP_LO){1'b0}}, prod[GP_LO-1:0]};
      end
      S_HI: begin
        mul_a = {{(MUL_W-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
        mul_b = {{(MUL_W-GP_HI){1'b0}}, gp[GP_W-1:GP_LO]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Divider requests: gain difference first, pan difference when it finishes
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = gmag;
    div_req.divisor  = n;
    if (state == S_JUMP && n != '0) begin
      div_req.start = 1'b1;
    end else if (state == S_DIVG && div_rsp.done) begin
      div_req.start    = 1'b1;
      div_req.dividend = {{(DIV_W-PAN_BITS-1){1'b0}}, pmag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      mono_source  <= 1'b0;
      current_gain <= UNITY_GAIN;
      target_gain  <= UNITY_GAIN;
      gain_step    <= '0;
      current_pan  <= '0;
      target_pan   <= '0;
      pan_step     <= '0;
      frames_left  <= '0;
    end else begin
      if (cfg_we) mono_source <= cfg_data;
      // load a new result, else drop the old one once transferred
      if (fin_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= (action == ACT_FRAME) ? S_PANF : S_LVL;
        end
        S_LVL:   state <= S_MULX;
        S_MULX:  state <= S_EXP;
        S_EXP:   state <= S_MULF;
        S_MULF:  state <= S_MANT;
        S_MANT:  state <= S_SHIFT;
        S_SHIFT: begin
          target_gain <= g_sat;
          state       <= S_JUMP;
        end
        S_JUMP: begin
          target_pan <= pan_c;
          if (n == '0) begin
            current_gain <= target_gain;
            current_pan  <= pan_c;
            gain_step    <= '0;
            pan_step     <= '0;
            frames_left  <= '0;
            state        <= S_IDLE;
          end else begin
            state <= S_DIVG;
          end
        end
        S_DIVG: begin
          if (div_rsp.done) begin
            gain_step <= gstep_v;
            state     <= S_DIVP;
          end
        end
        S_DIVP: begin
          if (div_rsp.done) begin
            pan_step    <= pstep_v;
            frames_left <= n;
            state       <= S_IDLE;
          end
        end
        S_PANF:  state <= active_r ? S_GP : S_FIN;
        S_GP:    state <= S_LO;
        S_LO:    state <= S_HI;
        S_HI:    state <= S_ACC;
        S_ACC:   state <= S_ABS;
        S_ABS:   state <= S_RND;
        S_RND:   state <= side ? S_FIN : S_GP;
        S_FIN: begin
          if (fin_go) begin
            // advance the glide; snap to target on its last frame
            if (frames_left == RAMP_BITS'(1)) begin
              current_gain <= target_gain;
              current_pan  <= target_pan;
              gain_step    <= '0;
              pan_step     <= '0;
              frames_left  <= '0;
            end else if (frames_left != '0) begin
              current_gain <= gain_sum[GAIN_BITS-1:0];
              current_pan  <= current_pan + pan_step;
              frames_left  <= frames_left - 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      active_r <= active;
      trim_r   <= trim_db;
      fader_r  <= fader_db;
      pan_r    <= pan_pos;
      frames_r <= ramp_frames;
      left_r   <= in_left;
      right_r  <= in_right;
    end
    case (state)
      S_LVL: begin
        db    <= {trim_c[LEVEL_BITS-1], trim_c} + {fader_c[LEVEL_BITS-1], fader_c};
        pan_c <= pan_cl;
        n     <= n_clamp;
      end
      S_EXP: begin
        e_r     <= prod[X_FRAC+E_BITS-1:X_FRAC];
        r_r     <= prod[R_BITS-1:0];
        base_r  <= tab_lo;
        slope_r <= tab_hi - tab_lo;
      end
      S_MANT: m_r <= base_r + prod[R_BITS+MANT_BITS-1:R_BITS];
      S_JUMP: div_neg <= gdiff[DIV_W-1];
      S_DIVG: begin
        if (div_rsp.done) div_neg <= pdiff[PAN_BITS];
      end
      S_PANF: begin
        lpf   <= lpf_v;
        rpf   <= rpf_v;
        side  <= 1'b0;
        res_l <= '0;
        res_r <= '0;
      end
      S_LO:  gp  <= prod[GP_W-1:0];
      S_HI:  acc <= prod_x;
      S_ACC: acc <= acc + (prod_x <<< GP_LO);
      S_ABS: begin
        neg <= acc[ACC_W-1];
        mag <= acc[ACC_W-1] ? -acc : acc;
      end
      S_RND: begin
        if (side) res_r <= res_v;
        else res_l <= res_v;
        side <= 1'b1;
      end
      default: begin
      end
    endcase
    if (fin_go) begin
      out_left  <= res_l;
      out_right <= res_r;
      ramping   <= (frames_left > RAMP_BITS'(1));
    end
  end

endmodule

`default_nettype wire

### sv/sgpr_chk.sv
`default_nettype none
`include "strip_gain_pan_ramp_top_macros.svh"

module sgpr_chk
  import sgpr_pkg::*;
(
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          action,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic signed [SAMPLE_BITS-1:0] out_left,
  input wire logic signed [SAMPLE_BITS-1:0] out_right,
  input wire logic                          ramping
);

  // a waiting result holds until transferred
  `SGPR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_left) && $stable(out_right) && $stable(ramping), "output changed while stalled")

  `SGPR_ASSERT_RST(a_rst_empty, rst, !out_valid, "result present after reset")

  // one item at a time
  `SGPR_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "second item taken while busy")

  // set-level items give no result
  `SGPR_ASSERT_NEXT(a_set_silent, in_valid && in_ready && (action == ACT_SET_LEVEL) && !out_valid, !out_valid, "result from set-level item")

endmodule

bind strip_gain_pan_ramp_top sgpr_chk u_sgpr_chk (.*);

`default_nettype wire

### dv/tb_strip_gain_pan_ramp_top.sv
`default_nettype none

module tb_strip_gain_pan_ramp_top;
  import sgpr_pkg::*;

  localparam int CYCLE_LIMIT   = 1500000;
  localparam int GLIDE_SETTLE  = 80;   // long enough for a set-level glide setup to finish
  localparam int HOLD_CYCLES   = 400;

  // 2^(j/16) in Q16
  localparam longint unsigned POW2_FRAC [17] = '{
    65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752, 92682,
    96785, 101070, 105545, 110218, 115097, 120193, 125515, 131072
  };

  typedef struct {
    bit                          action;
    logic signed [LEVEL_BITS-1:0] trim;
    logic signed [LEVEL_BITS-1:0] fader;
    logic signed [LEVEL_BITS-1:0] pan;
    logic [RAMP_BITS-1:0]         frames;
    bit                           active;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } strip_item_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          ramping;
  } mix_out_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic                          cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic                          action;
  logic signed [LEVEL_BITS-1:0]  trim_db;
  logic signed [LEVEL_BITS-1:0]  fader_db;
  logic signed [LEVEL_BITS-1:0]  pan_pos;
  logic        [LEVEL_BITS-1:0]  ramp_frames;
  logic                          active;
  logic signed [SAMPLE_BITS-1:0] in_left;
  logic signed [SAMPLE_BITS-1:0] in_right;
  logic                          out_valid;
  logic                          out_ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  logic                          ramping;

  strip_gain_pan_ramp_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .trim_db     (trim_db),
    .fader_db    (fader_db),
    .pan_pos     (pan_pos),
    .ramp_frames (ramp_frames),
    .active      (active),
    .in_left     (in_left),
    .in_right    (in_right),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_left    (out_left),
    .out_right   (out_right),
    .ramping     (ramping)
  );

  // Strip state as the block should hold it
  bit                           mono_cfg;
  logic [GAIN_BITS-1:0]         cur_gain;
  logic [GAIN_BITS-1:0]         tgt_gain;
  logic signed [GAIN_BITS:0]    gain_step;
  logic signed [PAN_BITS-1:0]   cur_pan;
  logic signed [PAN_BITS-1:0]   tgt_pan;
  logic signed [PAN_BITS-1:0]   pan_step;
  logic [RAMP_BITS-1:0]         frames_left;

  mix_out_t pending_mix [$];

  int  err_cnt;
  int  n_in;
  int  n_out;
  int  n_level;
  int  n_quiet;
  int  n_mono_frames;
  int  n_stereo_frames;
  int  burst_left;
  bit  pace_on;
  bit  rx_hold_req;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void reset_strip_state();
    mono_cfg    = 1'b0;
    cur_gain    = UNITY_GAIN;
    tgt_gain    = UNITY_GAIN;
    gain_step   = '0;
    cur_pan     = '0;
    tgt_pan     = '0;
    pan_step    = '0;
    frames_left = '0;
  endfunction

  function automatic logic [GAIN_BITS-1:0] db_to_lin_gain(input int db_q8);
    longint          x;
    longint          e;
    longint unsigned xo;
    longint unsigned f;
    longint unsigned r;
    longint unsigned m;
    longint unsigned g;
    int              j;
    int              s;
    x  = longint'(db_q8) * DB_LOG2_K;
    xo = x + (longint'(32) << 24);
    e  = longint'(xo >> 24) - 32;
    f  = xo & 64'hFF_FFFF;
    j  = int'(f >> 20) & 15;
    r  = f & 64'hF_FFFF;
    m  = POW2_FRAC[j] + (((POW2_FRAC[j+1] - POW2_FRAC[j]) * r) >> 20);
    if (e >= 0) begin
      if (e > 16) return GAIN_MAX;
      g = m << e;
    end else begin
      s = int'(-e);
      if (s > 40) return '0;
      g = (m + (64'd1 << (s - 1))) >> s;
    end
    return (g > GAIN_MAX) ? GAIN_MAX : g[GAIN_BITS-1:0];
  endfunction

  // Round half away from zero, then saturate to the sample width
  function automatic logic signed [SAMPLE_BITS-1:0] apply_gain_pan(
    input logic signed [SAMPLE_BITS-1:0] smp,
    input logic [GAIN_BITS-1:0]          gain,
    input int                            panf
  );
    longint          p;
    longint          v;
    longint          hi;
    longint unsigned mag;
    bit              neg;
    hi  = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    p   = longint'(smp) * longint'(gain) * longint'(panf);
    neg = (p < 0);
    mag = neg ? -p : p;
    mag = (mag + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
    if (mag > hi + 1) mag = hi + 1;
    v = neg ? -longint'(mag) : longint'(mag);
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v[SAMPLE_BITS-1:0];
  endfunction

  function automatic void glide_one_frame();
    longint g;
    if (frames_left == 0) return;
    g           = longint'(cur_gain) + longint'(gain_step);
    cur_gain    = g[GAIN_BITS-1:0];
    cur_pan     = cur_pan + pan_step;
    frames_left = frames_left - 1'b1;
    if (frames_left == 0) begin
      // snap on the last frame
      cur_gain  = tgt_gain;
      cur_pan   = tgt_pan;
      gain_step = '0;
      pan_step  = '0;
    end
  endfunction

  function automatic void level_stage_step(input strip_item_t it);
    int       trim;
    int       fader;
    int       pan;
    int       lp;
    int       rp;
    longint   q;
    mix_out_t res;
    if (it.action == ACT_SET_LEVEL) begin
      trim  = it.trim;
      fader = it.fader;
      pan   = it.pan;
      if (trim < int'(TRIM_MIN)) trim = TRIM_MIN;
      if (trim > int'(TRIM_MAX)) trim = TRIM_MAX;
      if (fader < int'(FADER_MIN)) fader = FADER_MIN;
      if (fader > int'(FADER_MAX)) fader = FADER_MAX;
      if (pan < int'(PAN_NEG_ONE)) pan = PAN_NEG_ONE;
      if (pan > int'(PAN_ONE)) pan = PAN_ONE;
      tgt_gain = db_to_lin_gain(trim + fader);
      tgt_pan  = pan[PAN_BITS-1:0];
      if (it.frames == 0) begin
        cur_gain    = tgt_gain;
        cur_pan     = tgt_pan;
        gain_step   = '0;
        pan_step    = '0;
        frames_left = '0;
      end else begin
        q         = (longint'(tgt_gain) - longint'(cur_gain)) / longint'(it.frames);
        gain_step = q[GAIN_BITS:0];
        q         = (longint'(tgt_pan) - longint'(cur_pan)) / longint'(it.frames);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        pan_step    = q[PAN_BITS-1:0];
        frames_left = it.frames;
      end
      n_level++;
      return;
    end
    if (it.active) begin
      lp = PAN_ONE;
      rp = PAN_ONE;
      if (mono_cfg) begin
        lp = int'(PAN_ONE) - int'(cur_pan);
        rp = int'(PAN_ONE) + int'(cur_pan);
        if (lp > int'(PAN_ONE)) lp = PAN_ONE;
        if (rp > int'(PAN_ONE)) rp = PAN_ONE;
        if (lp < 0) lp = 0;
        if (rp < 0) rp = 0;
        n_mono_frames++;
      end else begin
        n_stereo_frames++;
      end
      res.left  = apply_gain_pan(it.left, cur_gain, lp);
      res.right = apply_gain_pan(it.right, cur_gain, rp);
    end else begin
      res.left  = '0;
      res.right = '0;
      n_quiet++;
    end
    glide_one_frame();
    res.ramping = (frames_left != 0);
    pending_mix.insert(pending_mix.size(), res);
  endfunction

  function automatic strip_item_t level_item(input int trim, input int fader, input int pan,
                                             input int frames);
    strip_item_t it;
    it.action = ACT_SET_LEVEL;
    it.trim   = trim[LEVEL_BITS-1:0];
    it.fader  = fader[LEVEL_BITS-1:0];
    it.pan    = pan[LEVEL_BITS-1:0];
    it.frames = frames[RAMP_BITS-1:0];
    it.active = 1'($urandom_range(1));
    it.left   = SAMPLE_BITS'($urandom);
    it.right  = SAMPLE_BITS'($urandom);
    return it;
  endfunction

  function automatic strip_item_t frame_item(input bit act, input int l, input int r);
    strip_item_t it;
    it.action = ACT_FRAME;
    it.trim   = LEVEL_BITS'($urandom);
    it.fader  = LEVEL_BITS'($urandom);
    it.pan    = LEVEL_BITS'($urandom);
    it.frames = RAMP_BITS'($urandom);
    it.active = act;
    it.left   = l[SAMPLE_BITS-1:0];
    it.right  = r[SAMPLE_BITS-1:0];
    return it;
  endfunction

  // Plausible levels half the time, otherwise the whole 16-bit range
  function automatic int rand_level(input int lo, input int hi);
    if ($urandom_range(1)) return int'($signed(16'($urandom)));
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int rand_sample();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 8388607 : -8388608;
      1:       return int'($urandom_range(2000)) - 1000;
      default: return int'($signed(24'($urandom)));
    endcase
  endfunction

  function automatic int rand_frames();
    case ($urandom_range(4))
      0:       return 0;
      1, 2:    return $urandom_range(1, 16);
      3:       return $urandom_range(17, 200);
      default: return $urandom_range(65535);
    endcase
  endfunction

  function automatic strip_item_t rand_level_item();
    return level_item(rand_level(-8000, 8000), rand_level(-17000, 4000),
                      rand_level(-18000, 18000), rand_frames());
  endfunction

  function automatic strip_item_t rand_frame_item();
    return frame_item($urandom_range(99) < 85, rand_sample(), rand_sample());
  endfunction

  task automatic pace_sender();
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 60 : 8)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
    end
  endtask

  task automatic push_item(input strip_item_t it);
    @(negedge clk);
    in_valid    = 1'b1;
    action      = it.action;
    trim_db     = it.trim;
    fader_db    = it.fader;
    pan_pos     = it.pan;
    ramp_frames = it.frames;
    active      = it.active;
    in_left     = it.left;
    in_right    = it.right;
    do @(posedge clk); while (!in_ready);
    level_stage_step(it);
    n_in++;
    if (pace_on) pace_sender();
  endtask

  // Drain all results and let any glide setup finish before touching the register
  task automatic set_mono(input bit v);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_mix.size() != 0) @(posedge clk);
    repeat (GLIDE_SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = v;
    @(posedge clk);
    mono_cfg = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic test_directed_levels();
    set_mono(1'b1);
    // both level extremes saturate; hard left pan
    push_item(level_item(32767, 32767, -32768, 0));
    push_item(frame_item(1'b1, 8388607, -8388608));
    push_item(frame_item(1'b1, -8388608, 8388607));
    // bottom extremes, one-frame glide from hard left to hard right saturates the pan step
    push_item(level_item(-32768, -32768, 32767, 1));
    push_item(frame_item(1'b1, 1234567, -7654321));
    push_item(frame_item(1'b0, 8388607, 8388607));
    push_item(frame_item(1'b1, 8388607, -8388608));
    // longest glide
    push_item(level_item(0, 0, 0, 65535));
    push_item(frame_item(1'b1, 8388607, -8388608));
    push_item(frame_item(1'b0, -1, 1));
    push_item(frame_item(1'b1, 4000000, -4000000));
    // short glide that ends inside this group
    push_item(level_item(256, -512, 8192, 3));
    push_item(frame_item(1'b1, 100000, -100000));
    push_item(frame_item(1'b0, 100000, -100000));
    push_item(frame_item(1'b1, 100000, -100000));
    push_item(frame_item(1'b1, 100000, -100000));
    // stereo strip: pan tracked but ignored
    set_mono(1'b0);
    push_item(level_item(6144, 2560, -16384, 2));
    push_item(frame_item(1'b1, 8388607, -8388608));
    push_item(frame_item(1'b1, -1, 1));
    push_item(frame_item(1'b1, 0, 0));
    push_item(level_item(-6144, -15360, 16384, 0));
    push_item(frame_item(1'b1, 8388607, -8388608));
  endtask

  task automatic run_scene_phase(input int n_items, input bit mono);
    int sent;
    int k;
    sent = 0;
    set_mono(mono);
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        // noise: lone items of either kind
        push_item($urandom_range(1) ? rand_frame_item() : rand_level_item());
        sent++;
      end else begin
        push_item(rand_level_item());
        k = $urandom_range(1, 24);
        repeat (k) push_item(rand_frame_item());
        sent += k + 1;
      end
    end
  endtask

  task automatic test_random_scenes();
    run_scene_phase(340, 1'b1);
    run_scene_phase(340, 1'b0);
    run_scene_phase(340, 1'b1);
    run_scene_phase(340, 1'b0);
  endtask

  task automatic test_output_backpressure();
    set_mono(1'b1);
    pace_on     = 1'b0;
    rx_hold_req = ~rx_hold_req;
    push_item(level_item(rand_level(-6144, 6144), rand_level(-15360, 2560),
                         rand_level(-16384, 16384), 30));
    repeat (60) push_item(rand_frame_item());
    pace_on = 1'b1;
    repeat (40) push_item(rand_frame_item());
  endtask

  // Receiver: stall pattern in windows of varying density, plus a long hold on request
  initial begin : rx_pacer
    int  win_cnt;
    int  stall_pct;
    int  hold_cnt;
    bit  hold_seen;
    win_cnt   = 0;
    stall_pct = 0;
    hold_cnt  = 0;
    hold_seen = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req != hold_seen) begin
        hold_seen = rx_hold_req;
        hold_cnt  = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        out_ready = 1'b0;
        hold_cnt--;
      end else begin
        if (win_cnt == 0) begin
          case ($urandom_range(3))
            0:       stall_pct = 0;
            1:       stall_pct = 20;
            2:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
          win_cnt = $urandom_range(50, 200);
        end
        win_cnt--;
        out_ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare each output transfer with the oldest expected frame
  initial begin : mix_checker
    mix_out_t exp_res;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        n_out++;
        if (pending_mix.size() == 0) begin
          err_cnt++;
          $error("unexpected output transfer: out_left %0d out_right %0d ramping %0b",
                 out_left, out_right, ramping);
        end else begin
          exp_res = pending_mix.pop_front();
          if (out_left !== exp_res.left) begin
            err_cnt++;
            $error("out_left: expected %0d, got %0d", exp_res.left, out_left);
          end
          if (out_right !== exp_res.right) begin
            err_cnt++;
            $error("out_right: expected %0d, got %0d", exp_res.right, out_right);
          end
          if (ramping !== exp_res.ramping) begin
            err_cnt++;
            $error("ramping: expected %0b, got %0b", exp_res.ramping, ramping);
          end
        end
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : main
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_data    = 1'b0;
    in_valid    = 1'b0;
    action      = ACT_SET_LEVEL;
    trim_db     = '0;
    fader_db    = '0;
    pan_pos     = '0;
    ramp_frames = '0;
    active      = 1'b0;
    in_left     = '0;
    in_right    = '0;
    err_cnt     = 0;
    n_in        = 0;
    n_out       = 0;
    n_level     = 0;
    n_quiet     = 0;
    n_mono_frames   = 0;
    n_stereo_frames = 0;
    burst_left  = 1;
    pace_on     = 1'b1;
    rx_hold_req = 1'b0;
    reset_strip_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_levels();
    test_random_scenes();
    test_output_backpressure();

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_mix.size() != 0) @(posedge clk);
    repeat (GLIDE_SETTLE) @(posedge clk);

    $display("Run covered %0d input transfers (%0d level changes) and %0d results:",
             n_in, n_level, n_out);
    $display("  %0d panned mono, %0d stereo and %0d muted frames, with a long output hold",
             n_mono_frames, n_stereo_frames, n_quiet);
    if (err_cnt == 0 && pending_mix.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
